// File: src/kvlp_pkg.sv
package kvlp_pkg;

    // Token stages of the line scanner.
    typedef enum logic [2:0] {
        ST_GAP      = 3'd0,
        ST_KEY1     = 3'd1,
        ST_KEYN     = 3'd2,
        ST_NUMSTART = 3'd3,
        ST_DIGITS   = 3'd4,
        ST_NUMDONE  = 3'd5,
        ST_DEAD     = 3'd6
    } t_stage;

    // One byte of a line as it moves from the input register to the parser.
    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_line;
    } t_byte;

    // One result: the stored values and the page code.
    typedef struct packed {
        logic signed [31:0] field_c;
        logic signed [31:0] field_v;
        logic signed [31:0] field_i;
        logic signed [31:0] field_u;
        logic [3:0]         page_code;
    } t_result;

    // Character codes.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_UP_I  = 8'h49;
    localparam logic [7:0] CH_UP_P  = 8'h50;
    localparam logic [7:0] CH_UP_R  = 8'h52;
    localparam logic [7:0] CH_UP_S  = 8'h53;
    localparam logic [7:0] CH_UP_U  = 8'h55;
    localparam logic [7:0] CH_LO_C  = 8'h63;
    localparam logic [7:0] CH_LO_O  = 8'h6F;
    localparam logic [7:0] CH_LO_S  = 8'h73;
    localparam logic [7:0] CH_LO_T  = 8'h74;
    localparam logic [7:0] CH_LO_V  = 8'h76;

    // Page codes.
    localparam logic [3:0] PAGE_NONE = 4'd0;
    localparam logic [3:0] PAGE_POS  = 4'd9;
    localparam logic [3:0] PAGE_T    = 4'd10;
    localparam logic [3:0] PAGE_RS   = 4'd12;

    // Number limits.
    localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;
    localparam logic [31:0] POS_MAX   = 32'h7FFF_FFFF;

    // Expected byte of the "Pos" prefix at a given line position.
    function automatic logic [7:0] prefix_char(input logic [1:0] pos);
        logic [7:0] c;
        case (pos)
            2'd0:    c = CH_UP_P;
            2'd1:    c = CH_LO_O;
            2'd2:    c = CH_LO_S;
            default: c = CH_NUL;
        endcase
        return c;
    endfunction

endpackage

// File: src/kvlp_in_stage.sv
module kvlp_in_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [7:0]          i_char_code,
    input  logic                i_end_of_line,
    output logic                o_valid,
    output kvlp_pkg::t_byte     o_byte,
    input  logic                i_take
);

    logic            r_valid;
    kvlp_pkg::t_byte r_byte;

    // The register can load whenever it is empty or its byte leaves this cycle.
    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_byte  = r_byte;

    // Valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Byte payload.
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte.char_code   <= i_char_code;
            r_byte.end_of_line <= i_end_of_line;
        end
    end

endmodule

// File: src/kvlp_parse.sv
module kvlp_parse (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  kvlp_pkg::t_byte     i_byte,
    input  logic                i_out_free,
    output logic                o_take,
    output logic                o_res_valid,
    output kvlp_pkg::t_result   o_res
);

    // Line state.
    logic [1:0]       r_pos,    n_pos;
    logic             r_pmatch, n_pmatch;
    kvlp_pkg::t_stage r_stage,  n_stage;
    logic [7:0]       r_key1,   n_key1;
    logic [7:0]       r_key2,   n_key2;
    logic             r_neg,    n_neg;
    logic [31:0]      r_acc,    n_acc;

    // Stored values and page code.
    logic [31:0] r_val_c, n_val_c;
    logic [31:0] r_val_v, n_val_v;
    logic [31:0] r_val_i, n_val_i;
    logic [31:0] r_val_u, n_val_u;
    logic [3:0]  r_page,  n_page;

    logic [7:0]       ch;
    logic             eol;
    logic             digit;
    logic             sep;
    logic             hit;
    logic [35:0]      acc_ext;
    logic [35:0]      acc_sum;
    logic [31:0]      acc_dig;
    logic             do_commit;
    logic             commit_guard;
    kvlp_pkg::t_stage commit_stage;
    logic [31:0]      commit_val;

    assign ch  = i_byte.char_code;
    assign eol = i_byte.end_of_line;

    // A byte that ends a line needs a free result slot; others always go.
    assign o_take      = i_valid && (!eol || i_out_free);
    assign o_res_valid = o_take && eol;

    assign digit = (ch >= kvlp_pkg::CH_ZERO) && (ch <= kvlp_pkg::CH_NINE);
    assign sep   = (ch == kvlp_pkg::CH_SPACE) || (ch == kvlp_pkg::CH_NUL);

    // Accumulator times ten plus the new digit, saturated at the magnitude limit.
    assign acc_ext = {4'd0, r_acc};
    assign acc_sum = (acc_ext << 3) + (acc_ext << 1) + {32'd0, ch[3:0]};
    assign acc_dig = (acc_sum > {4'd0, kvlp_pkg::MAG_LIMIT}) ? kvlp_pkg::MAG_LIMIT
                                                             : acc_sum[31:0];

    always_comb begin
        n_pos    = r_pos;
        n_pmatch = r_pmatch;
        n_stage  = r_stage;
        n_key1   = r_key1;
        n_key2   = r_key2;
        n_neg    = r_neg;
        n_acc    = r_acc;
        n_val_c  = r_val_c;
        n_val_v  = r_val_v;
        n_val_i  = r_val_i;
        n_val_u  = r_val_u;
        n_page   = r_page;
        hit      = 1'b0;

        // Token scanner for this byte.
        if (r_stage != kvlp_pkg::ST_DEAD) begin
            if (ch == kvlp_pkg::CH_NUL) begin
                n_stage = kvlp_pkg::ST_DEAD;
            end else if (ch == kvlp_pkg::CH_SPACE) begin
                n_stage = kvlp_pkg::ST_GAP;
            end else begin
                case (r_stage)
                    kvlp_pkg::ST_GAP: begin
                        n_key1 = 8'd0;
                        n_key2 = 8'd0;
                        n_neg  = 1'b0;
                        n_acc  = 32'd0;
                        if (ch == kvlp_pkg::CH_EQ) begin
                            n_stage = kvlp_pkg::ST_NUMSTART;
                        end else begin
                            n_key1  = ch;
                            n_stage = kvlp_pkg::ST_KEY1;
                        end
                    end
                    kvlp_pkg::ST_KEY1: begin
                        if (ch == kvlp_pkg::CH_EQ) begin
                            n_stage = kvlp_pkg::ST_NUMSTART;
                        end else begin
                            n_key2  = ch;
                            n_stage = kvlp_pkg::ST_KEYN;
                        end
                    end
                    kvlp_pkg::ST_KEYN: begin
                        if (ch == kvlp_pkg::CH_EQ) begin
                            n_stage = kvlp_pkg::ST_NUMSTART;
                        end
                    end
                    kvlp_pkg::ST_NUMSTART: begin
                        if ((ch >= kvlp_pkg::CH_TAB) && (ch <= kvlp_pkg::CH_CR)) begin
                            n_stage = kvlp_pkg::ST_NUMSTART;
                        end else if (ch == kvlp_pkg::CH_PLUS) begin
                            n_stage = kvlp_pkg::ST_DIGITS;
                        end else if (ch == kvlp_pkg::CH_MINUS) begin
                            n_neg   = 1'b1;
                            n_stage = kvlp_pkg::ST_DIGITS;
                        end else if (digit) begin
                            n_acc   = acc_dig;
                            n_stage = kvlp_pkg::ST_DIGITS;
                        end else begin
                            n_stage = kvlp_pkg::ST_NUMDONE;
                        end
                    end
                    kvlp_pkg::ST_DIGITS: begin
                        if (digit) begin
                            n_acc = acc_dig;
                        end else begin
                            n_stage = kvlp_pkg::ST_NUMDONE;
                        end
                    end
                    default: begin
                        n_stage = r_stage;
                    end
                endcase
            end
        end

        // Prefix tracking over the first three bytes.
        if (r_pos != 2'd3) begin
            hit      = (ch == kvlp_pkg::prefix_char(r_pos));
            n_pmatch = (r_pos == 2'd0) ? hit : (r_pmatch && hit);
            n_pos    = r_pos + 2'd1;
        end

        // A token commits at a separator (state before the prefix update) or
        // at the end of the line (state after it). Only one can happen per byte.
        if (sep && (r_stage != kvlp_pkg::ST_DEAD)) begin
            do_commit    = 1'b1;
            commit_stage = r_stage;
            commit_guard = (r_pos == 2'd3) && r_pmatch;
        end else begin
            do_commit    = eol;
            commit_stage = n_stage;
            commit_guard = (n_pos == 2'd3) && n_pmatch;
        end

        if (n_neg) begin
            commit_val = 32'd0 - n_acc;
        end else begin
            commit_val = (n_acc > kvlp_pkg::POS_MAX) ? kvlp_pkg::POS_MAX : n_acc;
        end

        if (do_commit && !commit_guard && (commit_stage >= kvlp_pkg::ST_NUMSTART)
                && (commit_stage <= kvlp_pkg::ST_NUMDONE)) begin
            case (n_key1)
                kvlp_pkg::CH_LO_C: n_val_c = commit_val;
                kvlp_pkg::CH_LO_V: n_val_v = commit_val;
                kvlp_pkg::CH_UP_I: n_val_i = commit_val;
                kvlp_pkg::CH_UP_U: n_val_u = commit_val;
                kvlp_pkg::CH_LO_T: n_page  = kvlp_pkg::PAGE_T;
                kvlp_pkg::CH_UP_R: begin
                    if (n_key2 == kvlp_pkg::CH_UP_S) begin
                        n_page = kvlp_pkg::PAGE_RS;
                    end
                end
                default: n_page = n_page;
            endcase
        end

        // The third matching byte of a "Pos" line selects its page.
        if ((r_pos == 2'd2) && n_pmatch) begin
            n_page = kvlp_pkg::PAGE_POS;
        end

        // Result carries the values after the final commit.
        o_res.field_c   = n_val_c;
        o_res.field_v   = n_val_v;
        o_res.field_i   = n_val_i;
        o_res.field_u   = n_val_u;
        o_res.page_code = n_page;

        // The line state starts over after the last byte.
        if (eol) begin
            n_pos    = 2'd0;
            n_pmatch = 1'b0;
            n_stage  = kvlp_pkg::ST_GAP;
            n_key1   = 8'd0;
            n_key2   = 8'd0;
            n_neg    = 1'b0;
            n_acc    = 32'd0;
        end
    end

    // State registers, updated once per byte transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= 2'd0;
            r_pmatch <= 1'b0;
            r_stage  <= kvlp_pkg::ST_GAP;
            r_key1   <= 8'd0;
            r_key2   <= 8'd0;
            r_neg    <= 1'b0;
            r_acc    <= 32'd0;
            r_val_c  <= 32'd0;
            r_val_v  <= 32'd0;
            r_val_i  <= 32'd0;
            r_val_u  <= 32'd0;
            r_page   <= kvlp_pkg::PAGE_NONE;
        end else if (o_take) begin
            r_pos    <= n_pos;
            r_pmatch <= n_pmatch;
            r_stage  <= n_stage;
            r_key1   <= n_key1;
            r_key2   <= n_key2;
            r_neg    <= n_neg;
            r_acc    <= n_acc;
            r_val_c  <= n_val_c;
            r_val_v  <= n_val_v;
            r_val_i  <= n_val_i;
            r_val_u  <= n_val_u;
            r_page   <= n_page;
        end
    end

endmodule

// File: src/kvlp_out_stage.sv
module kvlp_out_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  kvlp_pkg::t_result   i_res,
    output logic                o_free,
    output logic                o_valid,
    input  logic                i_ready,
    output kvlp_pkg::t_result   o_res
);

    logic              r_valid;
    kvlp_pkg::t_result r_res;

    // The slot can take a new result when empty or when its result leaves now.
    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    // Valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

// File: src/key_value_line_parser_core.sv
// Result path: the last byte of a line passes the input register, then the result register;
// it waits in the input register only while the result slot is full.
// Throughput: one byte per cycle unless a line's last byte waits on a full result slot;
// the per-byte token and accumulator update is combinational between the two registers.
// Reset: i_rst_n is synchronous and active low; it clears the line state, the four stored
// values, the page code and both valid flags.
module key_value_line_parser_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_char_code,
    input  logic               i_end_of_line,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_field_c,
    output logic signed [31:0] o_field_v,
    output logic signed [31:0] o_field_i,
    output logic signed [31:0] o_field_u,
    output logic [3:0]         o_page_code
);

    logic              byte_valid;
    kvlp_pkg::t_byte   byte_data;
    logic              take;
    logic              out_free;
    logic              res_valid;
    kvlp_pkg::t_result res_data;
    kvlp_pkg::t_result out_data;

    // Input register.
    kvlp_in_stage u_in (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_in_valid),
        .o_ready       (o_in_ready),
        .i_char_code   (i_char_code),
        .i_end_of_line (i_end_of_line),
        .o_valid       (byte_valid),
        .o_byte        (byte_data),
        .i_take        (take)
    );

    // Parser state and value storage.
    kvlp_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (byte_valid),
        .i_byte      (byte_data),
        .i_out_free  (out_free),
        .o_take      (take),
        .o_res_valid (res_valid),
        .o_res       (res_data)
    );

    // Result register.
    kvlp_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (res_valid),
        .i_res   (res_data),
        .o_free  (out_free),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_res   (out_data)
    );

    assign o_field_c   = out_data.field_c;
    assign o_field_v   = out_data.field_v;
    assign o_field_i   = out_data.field_i;
    assign o_field_u   = out_data.field_u;
    assign o_page_code = out_data.page_code;

endmodule

// File: src/kvlp_checker.sv
module kvlp_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               i_end_of_line,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic signed [31:0] o_field_c,
    input logic signed [31:0] o_field_v,
    input logic signed [31:0] o_field_i,
    input logic signed [31:0] o_field_u,
    input logic [3:0]         o_page_code
);

    // Reset leaves no result pending and the input open.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && o_in_ready))
        else $error("result pending or input closed after reset");

    // A stalled result holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_field_c)
            && $stable(o_field_v) && $stable(o_field_i) && $stable(o_field_u)
            && $stable(o_page_code)))
        else $error("stalled result changed");

    // Only the defined page codes can appear.
    a_page_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_page_code == kvlp_pkg::PAGE_NONE)
            || (o_page_code == kvlp_pkg::PAGE_POS) || (o_page_code == kvlp_pkg::PAGE_T)
            || (o_page_code == kvlp_pkg::PAGE_RS)))
        else $error("undefined page code");

    // With the result slot empty the input side never stalls.
    a_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty result slot");

    // A mid-line input transfer while the output is empty cannot close the input.
    a_stream: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && !i_end_of_line && !o_out_valid) |=> o_in_ready)
        else $error("input closed after a mid-line transfer");

endmodule

bind key_value_line_parser_core kvlp_checker u_kvlp_checker (.*);
